FILE: rtl/cvs_pkg.sv
// Shared constants and controller/datapath interface types for the Chebyshev evaluator.
`default_nettype none

package cvs_pkg;

  localparam int unsigned FracBits   = 30;
  localparam int unsigned PointW     = 32;
  localparam int unsigned DegreeW    = 8;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned SlopeW     = 47;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned OutDataW   = 80;
  localparam int unsigned ChunkW     = 24;
  localparam int unsigned ProdW      = 56;
  localparam int unsigned AccW       = 79;

  localparam logic signed [PointW-1:0] OneFx = PointW'(64'd1 << FracBits);
  localparam logic signed [PointW-1:0] MinusOneFx = -OneFx;

  typedef struct packed {
    logic load;
    logic abs_en;
    logic mul_en;
    logic mul_sel_d;
    logic mul_hi;
    logic acc_load;
    logic acc_add;
    logic rnd_t;
    logic rnd_d;
    logic step;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic no_steps;
    logic last_step;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/cvs_ctrl.sv
// Controller: request handshakes, step sequencing and the output valid flag.
`default_nettype none

module cvs_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  wire logic         m_ready_i,
  input  wire cvs_pkg::sts_t sts_i,
  output cvs_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RUN,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    PH_ABS,
    PH_MUL_TLO,
    PH_MUL_THI,
    PH_MUL_DLO,
    PH_MUL_DHI,
    PH_ACC_D,
    PH_RND_D,
    PH_STEP
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o = '0;
    cmd_o.load    = (state_q == ST_IDLE) && s_valid_i;
    cmd_o.capture = (state_q == ST_FINISH) && (!out_valid_q || m_ready_i);
    if (state_q == ST_RUN) begin
      unique case (phase_q)
        PH_ABS: begin
          cmd_o.abs_en = 1'b1;
        end
        PH_MUL_TLO: begin
          cmd_o.mul_en = 1'b1;
        end
        PH_MUL_THI: begin
          cmd_o.mul_en   = 1'b1;
          cmd_o.mul_hi   = 1'b1;
          cmd_o.acc_load = 1'b1;
        end
        PH_MUL_DLO: begin
          cmd_o.mul_en    = 1'b1;
          cmd_o.mul_sel_d = 1'b1;
          cmd_o.acc_add   = 1'b1;
        end
        PH_MUL_DHI: begin
          cmd_o.mul_en    = 1'b1;
          cmd_o.mul_sel_d = 1'b1;
          cmd_o.mul_hi    = 1'b1;
          cmd_o.acc_load  = 1'b1;
          cmd_o.rnd_t     = 1'b1;
        end
        PH_ACC_D: begin
          cmd_o.acc_add = 1'b1;
        end
        PH_RND_D: begin
          cmd_o.rnd_d = 1'b1;
        end
        PH_STEP: begin
          cmd_o.step = 1'b1;
        end
        default: begin
          cmd_o.step = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        phase_d = PH_ABS;
        state_d = sts_i.no_steps ? ST_FINISH : ST_RUN;
      end
      ST_RUN: begin
        phase_d = phase_e'(phase_q + 3'd1);
        if (phase_q == PH_STEP && sts_i.last_step) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (cmd_o.capture) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_ABS;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/cvs_dp.sv
// Datapath: recurrence registers, shared 32x24 multiplier, rounding and clamping.
`default_nettype none

module cvs_dp (
  input  wire logic                                clk_i,
  input  wire cvs_pkg::cmd_t                       cmd_i,
  output cvs_pkg::sts_t                            sts_o,
  input  wire logic signed [cvs_pkg::PointW-1:0]   point_i,
  input  wire logic        [cvs_pkg::DegreeW-1:0]  degree_i,
  output logic signed      [cvs_pkg::ValueW-1:0]   value_o,
  output logic signed      [cvs_pkg::SlopeW-1:0]   slope_o
);

  localparam logic [cvs_pkg::AccW:0] Half = (cvs_pkg::AccW+1)'(1) << (cvs_pkg::FracBits - 1);

  // Recurrence state.
  logic        [31:0] x2mag_q;
  logic               xneg_q;
  logic signed [31:0] t_prev_q, t_cur_q;
  logic signed [46:0] d_prev_q, d_cur_q;
  logic        [7:0]  rem_q;
  logic        [8:0]  m_q;
  logic        [16:0] sq_q;

  // Multiplier operands and products.
  logic        [30:0] bt_q;
  logic        [46:0] bd_q;
  logic               st_q, sd_q;
  logic        [cvs_pkg::ProdW-1:0] pp_q;
  logic        [cvs_pkg::AccW-1:0]  acc_q;
  logic        [31:0] rt_q;
  logic               rtn_q;
  logic        [47:0] rd_q;
  logic               rdn_q;

  logic signed [cvs_pkg::ValueW-1:0] value_q;
  logic signed [cvs_pkg::SlopeW-1:0] slope_q;

  logic signed [31:0] x_sat;
  logic        [31:0] x_mag;
  logic        [31:0] t_mag;
  logic        [46:0] d_mag;
  logic        [cvs_pkg::ChunkW-1:0] chunk;
  logic        [cvs_pkg::AccW:0] rnd_sum;
  logic signed [33:0] pt, t_next;
  logic signed [49:0] pd, d_next, d_lim;

  always_comb begin
    if (point_i > cvs_pkg::OneFx) begin
      x_sat = cvs_pkg::OneFx;
    end else if (point_i < cvs_pkg::MinusOneFx) begin
      x_sat = cvs_pkg::MinusOneFx;
    end else begin
      x_sat = point_i;
    end
    x_mag = x_sat[31] ? 32'(-x_sat) : x_sat;
    t_mag = t_cur_q[31] ? 32'(-t_cur_q) : t_cur_q;
    d_mag = d_cur_q[46] ? 47'(-d_cur_q) : d_cur_q;

    if (cmd_i.mul_sel_d) begin
      chunk = cmd_i.mul_hi ? {1'b0, bd_q[46:24]} : bd_q[23:0];
    end else begin
      chunk = cmd_i.mul_hi ? {17'd0, bt_q[30:24]} : bt_q[23:0];
    end

    // Round to nearest, ties away from zero, on the magnitude.
    rnd_sum = {1'b0, acc_q} + Half;

    pt     = rtn_q ? -34'(signed'({2'b00, rt_q})) : 34'(signed'({2'b00, rt_q}));
    t_next = pt - 34'(t_prev_q);
    pd     = rdn_q ? -50'(signed'({2'b00, rd_q})) : 50'(signed'({2'b00, rd_q}));
    d_next = pd + 50'(signed'({t_cur_q, 1'b0})) - 50'(d_prev_q);
    d_lim  = 50'(signed'({3'b000, sq_q, 30'd0}));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x2mag_q  <= {x_mag[30:0], 1'b0};
      xneg_q   <= x_sat[31];
      t_prev_q <= cvs_pkg::OneFx;
      d_prev_q <= '0;
      m_q      <= 9'd2;
      sq_q     <= 17'd4;
      if (degree_i == '0) begin
        t_cur_q <= cvs_pkg::OneFx;
        d_cur_q <= '0;
        rem_q   <= '0;
      end else begin
        t_cur_q <= x_sat;
        d_cur_q <= 47'(cvs_pkg::OneFx);
        rem_q   <= degree_i - 8'd1;
      end
    end

    if (cmd_i.abs_en) begin
      bt_q <= t_mag[30:0];
      bd_q <= d_mag;
      st_q <= xneg_q ^ t_cur_q[31];
      sd_q <= xneg_q ^ d_cur_q[46];
    end

    if (cmd_i.mul_en) begin
      pp_q <= x2mag_q * chunk;
    end

    if (cmd_i.acc_load) begin
      acc_q <= cvs_pkg::AccW'(pp_q);
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + (cvs_pkg::AccW'(pp_q) << cvs_pkg::ChunkW);
    end

    if (cmd_i.rnd_t) begin
      rt_q  <= rnd_sum[61:30];
      rtn_q <= st_q;
    end
    if (cmd_i.rnd_d) begin
      rd_q  <= rnd_sum[77:30];
      rdn_q <= sd_q;
    end

    if (cmd_i.step) begin
      t_prev_q <= t_cur_q;
      d_prev_q <= d_cur_q;
      if (t_next > 34'(cvs_pkg::OneFx)) begin
        t_cur_q <= cvs_pkg::OneFx;
      end else if (t_next < 34'(cvs_pkg::MinusOneFx)) begin
        t_cur_q <= cvs_pkg::MinusOneFx;
      end else begin
        t_cur_q <= t_next[31:0];
      end
      if (d_next > d_lim) begin
        d_cur_q <= d_lim[46:0];
      end else if (d_next < -d_lim) begin
        d_cur_q <= 47'(-d_lim);
      end else begin
        d_cur_q <= d_next[46:0];
      end
      // (m+1)^2 = m^2 + 2m + 1 keeps the slope bound without a multiplier.
      sq_q  <= sq_q + 17'({m_q, 1'b0}) + 17'd1;
      m_q   <= m_q + 9'd1;
      rem_q <= rem_q - 8'd1;
    end

    if (cmd_i.capture) begin
      value_q <= t_cur_q;
      slope_q <= d_cur_q;
    end
  end

  assign sts_o.no_steps  = (rem_q == 8'd0);
  assign sts_o.last_step = (rem_q == 8'd1);
  assign value_o = value_q;
  assign slope_o = slope_q;

endmodule

`default_nettype wire

FILE: rtl/chebyshev_value_and_slope_top.sv
// Top level of the Chebyshev first-kind value and slope evaluator.
`default_nettype none

// Each request carries a point x (signed, 30 fraction bits, saturated to [-1,1]) and an
// order n; the result carries T_n(x) and its derivative, both with 30 fraction bits.
// One request is processed at a time. Orders 0 and 1 need no order step; order n >= 2
// takes n-1 order steps, and every order step runs two products through one shared
// 32x24 multiplier in two halves each, then rounds and updates the recurrence. A
// finished result waits in the output register, and the next request is accepted
// while it waits.
module chebyshev_value_and_slope_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [31:0] point, [39:32] degree
  input  wire logic [39:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [31:0] poly_value, [78:32] poly_slope, [79] zero
  output logic [79:0]      m_axis_tdata_o
);

  cvs_pkg::cmd_t cmd;
  cvs_pkg::sts_t sts;
  logic signed [cvs_pkg::ValueW-1:0] value;
  logic signed [cvs_pkg::SlopeW-1:0] slope;

  cvs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  cvs_dp u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .point_i  (s_axis_tdata_i[31:0]),
    .degree_i (s_axis_tdata_i[39:32]),
    .value_o  (value),
    .slope_o  (slope)
  );

  assign m_axis_tdata_o = {1'b0, slope, value};

endmodule

`default_nettype wire

FILE: bench/chebyshev_value_and_slope_top_tb.sv
// Self-checking testbench for the Chebyshev first-kind value and slope evaluator.
module chebyshev_value_and_slope_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cvs_pkg::*;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned MaxOrder    = 255;
  localparam longint      OneFix      = longint'(1) << FracBits;
  localparam int unsigned MaxGap      = 60;
  localparam int unsigned PhaseItems  = 325;
  localparam int unsigned NumPhases   = 4;
  localparam int unsigned ItemBudget  = PhaseItems * NumPhases + 25;
  localparam int unsigned WorstItem   = 8 * MaxOrder + 3 + 2 * MaxGap;
  localparam int unsigned CycleLimit  = ItemBudget * WorstItem * 3;
  localparam int unsigned DrainCycles = 8 * MaxOrder + 3 + 20;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [SlopeW-1:0] slope;
  } cheb_result_t;

  // Holds the predicted value/slope pairs in request order and checks the block's output.
  class chebyshev_scoreboard;
    cheb_result_t pending_results[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
    endfunction

    // 2x*y formed exactly, rounded to nearest at FracBits, ties away from zero.
    function longint round_scaled_product(longint a, longint b);
      logic [127:0] mag_a;
      logic [127:0] mag_b;
      logic [127:0] rounded;
      bit           negative;
      negative = (a < 0) != (b < 0);
      mag_a    = {64'd0, 64'((a < 0) ? -a : a)};
      mag_b    = {64'd0, 64'((b < 0) ? -b : b)};
      rounded  = (mag_a * mag_b + (128'd1 << (FracBits - 1))) >> FracBits;
      if (rounded > (128'd1 << 62)) rounded = 128'd1 << 62;
      return negative ? -longint'(rounded[63:0]) : longint'(rounded[63:0]);
    endfunction

    function longint saturate(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function cheb_result_t evaluate(logic [PointW-1:0] point, logic [DegreeW-1:0] degree);
      longint       x2;
      longint       t_prev, t_cur, t_next;
      longint       d_prev, d_cur, d_next;
      longint       bound;
      int unsigned  order;
      cheb_result_t res;
      order = degree;
      if (order > MaxOrder) order = MaxOrder;
      t_cur = OneFix;
      d_cur = 0;
      if (order != 0) begin
        t_cur  = saturate(longint'($signed(point)), OneFix);
        x2     = 2 * t_cur;
        t_prev = OneFix;
        d_prev = 0;
        d_cur  = OneFix;
        for (int unsigned k = 1; k < order; k++) begin
          bound  = longint'((k + 1) * (k + 1)) * OneFix;
          t_next = saturate(round_scaled_product(x2, t_cur) - t_prev, OneFix);
          d_next = saturate(round_scaled_product(x2, d_cur) + 2 * t_cur - d_prev, bound);
          t_prev = t_cur;
          t_cur  = t_next;
          d_prev = d_cur;
          d_cur  = d_next;
        end
      end
      res.value = t_cur[ValueW-1:0];
      res.slope = d_cur[SlopeW-1:0];
      return res;
    endfunction

    function void note_request(logic [InDataW-1:0] data);
      pending_results.push_back(evaluate(data[PointW-1:0], data[PointW+:DegreeW]));
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      cheb_result_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, data);
        mismatches++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (data[ValueW-1:0] !== exp_res.value) begin
        $display("%0t ns: poly_value mismatch, expected %h, actual %h",
                 $time, exp_res.value, data[ValueW-1:0]);
        mismatches++;
      end
      if (data[ValueW+:SlopeW] !== exp_res.slope) begin
        $display("%0t ns: poly_slope mismatch, expected %h, actual %h",
                 $time, exp_res.slope, data[ValueW+:SlopeW]);
        mismatches++;
      end
      if (data[OutDataW-1] !== 1'b0) begin
        $display("%0t ns: padding bit mismatch, expected 0, actual %b", $time, data[OutDataW-1]);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  chebyshev_scoreboard sb = new();
  bit                  tx_gaps_on = 1'b1;
  bit                  rx_stalls_on = 1'b1;
  int unsigned         rx_count = 0;
  int unsigned         cycle_count = 0;

  chebyshev_value_and_slope_top i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(10, MaxGap);
  endfunction

  function automatic int unsigned next_gap();
    if (!tx_gaps_on || $urandom_range(0, 99) < 55) return 0;
    return pick_pause();
  endfunction

  always @(posedge clk_i) begin
    if (rx_count != 0) begin
      rx_count--;
    end else if (!rx_stalls_on) begin
      m_axis_tready_i <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_axis_tready_i <= 1'b0;
      rx_count = pick_pause() - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      rx_count = $urandom_range(0, 40);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The gap is taken before the request; valid is only lowered when a gap is taken.
  task automatic send_request(input logic [PointW-1:0] point, input logic [DegreeW-1:0] degree);
    int unsigned gap;
    gap = next_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= {degree, point};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(s_axis_tdata_i);
  endtask

  task automatic send_random_request();
    longint               p;
    logic [DegreeW-1:0]   degree;
    int unsigned          r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      p = longint'($urandom_range(0, 32'h8000_0000)) - OneFix;
    end else if (r < 80) begin
      p = ($urandom_range(0, 1) ? OneFix : -OneFix) + longint'($urandom_range(0, 64)) - 32;
    end else if (r < 90) begin
      p = longint'($urandom);
    end else begin
      p = longint'($urandom_range(0, 511)) - 256;
    end
    r = $urandom_range(0, 99);
    if (r < 80) degree = DegreeW'($urandom_range(0, 16));
    else if (r < 95) degree = DegreeW'($urandom_range(0, 63));
    else degree = DegreeW'($urandom_range(0, MaxOrder));
    send_request(p[PointW-1:0], degree);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: orders 0 and 1, both ends of x, saturation of x, the largest order.
    send_request(32'h0000_0000, 8'd0);
    send_request(32'h4000_0000, 8'd0);
    send_request(32'h4000_0000, 8'd1);
    send_request(32'hC000_0000, 8'd1);
    send_request(32'h0000_0000, 8'd1);
    send_request(32'h4000_0000, 8'd2);
    send_request(32'hC000_0000, 8'd2);
    send_request(32'h0000_0000, 8'd2);
    send_request(32'h2000_0000, 8'd3);
    send_request(32'h7FFF_FFFF, 8'd5);
    send_request(32'h8000_0000, 8'd5);
    send_request(32'h4000_0001, 8'd4);
    send_request(32'hBFFF_FFFF, 8'd4);
    send_request(32'h0000_0001, 8'd7);
    send_request(32'hFFFF_FFFF, 8'd8);
    send_request(32'h3FFF_FFFF, 8'd100);
    send_request(32'hC000_0001, 8'd64);
    send_request(32'h2000_0000, 8'd128);
    send_request(32'hE000_0000, 8'd200);
    send_request(32'h4000_0000, 8'd255);
    send_request(32'hC000_0000, 8'd255);
    send_request(32'h0000_0000, 8'd255);
    send_request(32'h1234_5678, 8'd9);
    drain_results();

    // Phases: both sides idle, no idling at all, back-pressure only, sender gaps only.
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      tx_gaps_on   = (phase == 0) || (phase == 3);
      rx_stalls_on = (phase == 0) || (phase == 2);
      for (int unsigned i = 0; i < PhaseItems; i++) send_random_request();
      drain_results();
    end

    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cvs_pkg.sv
rtl/cvs_ctrl.sv
rtl/cvs_dp.sv
rtl/chebyshev_value_and_slope_top.sv
bench/chebyshev_value_and_slope_top_tb.sv
